/* rtl/core/bta_pkg.sv */
// Shared types, constants and the digit-to-ASCII mapping for the number formatter.
package bta_pkg;

  localparam int VALUE_FIELD_W = 32;
  localparam int VALUE_EXT_W   = 64;
  localparam int DIGIT_W       = 4;
  localparam int CHAR_W        = 7;

  localparam logic [CHAR_W-1:0] ASCII_ZERO   = 7'd48;
  // 'A' minus ten, so that digit ten maps onto 'A'
  localparam logic [CHAR_W-1:0] ASCII_LETTER = 7'd55;
  localparam logic [DIGIT_W-1:0] DEC_MAX_DIGIT = 4'd9;
  localparam logic [DIGIT_W-1:0] BCD_ADJ_MIN   = 4'd5;
  localparam logic [DIGIT_W-1:0] BCD_ADJ       = 4'd3;

  typedef struct packed {
    logic [VALUE_FIELD_W-1:0] value;
    logic                     mode;
  } req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
  } rsp_t;

  typedef struct packed {
    logic clear;  // zero the digit
    logic conv;   // shift one bit in
    logic dec;    // apply the add-three correction before the shift
    logic emit;   // take the digit of the lower neighbour
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d <= DEC_MAX_DIGIT) begin
      return ASCII_ZERO + dx;
    end
    return ASCII_LETTER + dx;
  endfunction

endpackage

/* rtl/core/bta_cell.sv */
// One digit cell: double-dabble step in decimal, plain shift in hex, digit hand-over on output.
module bta_cell
  import bta_pkg::*;
(
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic               bit_in,
  input  logic [DIGIT_W-1:0] digit_in,
  output logic               bit_out,
  output logic [DIGIT_W-1:0] digit_q
);

  logic [DIGIT_W-1:0] digit;
  logic [DIGIT_W-1:0] digit_next;
  logic [DIGIT_W-1:0] corr;

  assign corr    = (ctrl.dec && digit >= BCD_ADJ_MIN) ? digit + BCD_ADJ : digit;
  assign bit_out = corr[DIGIT_W-1];
  assign digit_q = digit;

  always_comb begin
    priority if (ctrl.clear) begin
      digit_next = '0;
    end else if (ctrl.conv) begin
      digit_next = {corr[DIGIT_W-2:0], bit_in};
    end else if (ctrl.emit) begin
      digit_next = digit_in;
    end else begin
      digit_next = digit;
    end
  end

  always_ff @(posedge clk) begin
    digit <= digit_next;
  end

endmodule

/* rtl/core/bta_chain.sv */
// Row of digit cells, least significant at index zero; the top cell feeds the output.
module bta_chain
  import bta_pkg::*;
#(
  parameter int NCELL = 10
) (
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic               bit_in,
  output logic [DIGIT_W-1:0] top_digit
);

  logic [NCELL:0]     carry;
  logic [DIGIT_W-1:0] digits [NCELL+1];

  assign carry[0]  = bit_in;
  assign digits[0] = '0;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    bta_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .bit_in   (carry[i]),
      .digit_in (digits[i]),
      .bit_out  (carry[i+1]),
      .digit_q  (digits[i+1])
    );
  end

  // the carry out of the top cell is not needed: the row is wide enough
  assign top_digit = digits[NCELL];

endmodule

/* rtl/core/binary_to_ascii_number_formatter.sv */
// Top level of the binary to ASCII number formatter: control, serial feed and output register.
//
// Each accepted item (value, mode) is turned into its ASCII digits, most significant first,
// one result item per digit, with leading zeros dropped and the final digit marked by last.
// Mode 0 gives decimal, mode 1 upper-case hexadecimal; a zero value gives a single '0'.
// Only the low VALUE_WIDTH bits of value are used (zero-extended above 32 bits).
// The value is fed bit-serially, most significant bit first, into a row of four-bit digit
// cells: in decimal each cell applies the add-three correction before shifting (double
// dabble), in hex the cells simply shift, so the row then holds the nibbles. After that the
// row shifts whole digits towards its top cell, one per cycle while the output register can
// take a digit (a held digit stalls it; a dropped leading zero never does), and the top
// digit is either dropped as a leading zero or sent. An item passes an accept state, a
// conversion phase with one step per value bit (the serial feed sets this) and an emit
// phase over each cell of the row (10 cells at the default width). The next item is taken
// once the last digit sits in the output register, even while it still waits to be taken.
module binary_to_ascii_number_formatter
  import bta_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int W     = VALUE_WIDTH;
  // decimal digits of 2**W - 1; 1233/4096 approximates log10(2)
  localparam int NCELL = (VALUE_WIDTH * 1233) / 4096 + 1;
  localparam int BCW   = $clog2(W + 1);
  localparam int RCW   = $clog2(NCELL + 1);

  state_t state;
  state_t state_next;

  logic [W-1:0]       shreg;
  logic [BCW-1:0]     bit_cnt;
  logic [RCW-1:0]     remaining;
  logic               hex;
  logic               started;
  logic [VALUE_EXT_W-1:0] value_ext;
  logic [DIGIT_W-1:0] top_digit;
  cell_ctrl_t         ctrl;
  logic               take;
  logic               skip;

  assign req_ready = (state == ST_IDLE);
  assign value_ext = {{(VALUE_EXT_W-VALUE_FIELD_W){1'b0}}, req.value};

  // Next state and cell control.
  always_comb begin
    state_next = state;
    ctrl       = '0;
    take       = 1'b0;
    skip       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          ctrl.clear = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        ctrl.conv = 1'b1;
        ctrl.dec  = ~hex;
        if (bit_cnt == BCW'(1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // drop leading zeros, but always keep the final digit
        if (!started && top_digit == '0 && remaining != RCW'(1)) begin
          skip      = 1'b1;
          ctrl.emit = 1'b1;
        end else if (!rsp_valid || rsp_ready) begin
          take      = 1'b1;
          ctrl.emit = 1'b1;
          if (remaining == RCW'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Serial feed, counters and mode.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_valid) begin
      shreg     <= value_ext[W-1:0];
      bit_cnt   <= BCW'(W);
      remaining <= RCW'(NCELL);
      hex       <= req.mode;
    end else begin
      if (state == ST_CONV) begin
        shreg   <= shreg << 1;
        bit_cnt <= bit_cnt - BCW'(1);
      end
      if (take || skip) begin
        remaining <= remaining - RCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
    end else if (state == ST_IDLE && req_valid) begin
      started <= 1'b0;
    end else if (take) begin
      started <= 1'b1;
    end
  end

  bta_chain #(
    .NCELL (NCELL)
  ) u_chain (
    .clk       (clk),
    .ctrl      (ctrl),
    .bit_in    (shreg[W-1]),
    .top_digit (top_digit)
  );

  // Output register: hold the digit until taken, advance on take.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (take) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp.digit_char <= digit_ascii(top_digit);
      rsp.last       <= (remaining == RCW'(1));
    end
  end

endmodule
